FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types and constants of the grid path search unit.
// ----------------------------------------------------------------------------
package gaps_pkg;

  // largest grid the stores hold; the command ports are sized for 32x32
  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 32;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FILL, ST_PRD, ST_CHK_S, ST_CHK_G, ST_CHK_D, ST_CLR, ST_INIT,
    ST_SCAN, ST_SCAN_WAIT, ST_SCAN_DONE, ST_NB_ADDR, ST_NB_UPD,
    ST_LEN_RD, ST_LEN_DT, ST_WR_RD, ST_WR_DT
  } state_t;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_FIND = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // Q8 step costs and octile weight
  localparam logic [8:0] STEP_STRAIGHT  = 9'd256;
  localparam logic [8:0] STEP_DIAG      = 9'd362;
  localparam logic [6:0] OCT_MIN_WEIGHT = 7'd106;

  // neighbour offsets: four straight first, then four diagonal
  localparam logic signed [1:0] NB_DX [8] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0,
                                              2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] NB_DY [8] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1,
                                              2'sd1, -2'sd1, 2'sd1, -2'sd1};

endpackage

FILE: src/gaps_heur.sv
// ----------------------------------------------------------------------------
// gaps_heur
// Registered Q8 Manhattan / octile distance estimate, saturated.
// ----------------------------------------------------------------------------
module gaps_heur #(
  parameter int XW = 5,
  parameter int YW = 5,
  parameter int CW = 24
) (
  input  logic          clk,
  input  logic [XW-1:0] x,
  input  logic [YW-1:0] y,
  input  logic [XW-1:0] gx,
  input  logic [YW-1:0] gy,
  input  logic          diag,
  output logic [CW-1:0] h
);
  import gaps_pkg::*;

  localparam logic [32:0] CMAX = (33'd1 << CW) - 33'd1;

  logic [XW-1:0] dx;
  logic [YW-1:0] dy;
  logic [31:0]   mx, mn;
  logic [32:0]   hw;

  always_comb begin
    dx = (x > gx) ? x - gx : gx - x;
    dy = (y > gy) ? y - gy : gy - y;
    if (32'(dx) > 32'(dy)) begin
      mx = 32'(dx);
      mn = 32'(dy);
    end else begin
      mx = 32'(dy);
      mn = 32'(dx);
    end
    if (diag) begin
      hw = 33'(mx) * 33'(STEP_STRAIGHT) + 33'(mn) * 33'(OCT_MIN_WEIGHT);
    end else begin
      hw = (33'(dx) + 33'(dy)) * 33'(STEP_STRAIGHT);
    end
  end

  always_ff @(posedge clk) begin
    h <= (hw > CMAX) ? {CW{1'b1}} : hw[CW-1:0];
  end

endmodule

FILE: src/grid_astar_path_search_unit.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// Occupancy grid with A* search, path store and path read-back.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// cmd     | in        | start & !busy       | kind, first_x/y, second_x/y, blocked_value,
//         |           |                     | diagonal, path_index
// result  | out       | done (one cycle)    | status, path_length, path_x, path_y
// cfg     | in        | cfg_valid&cfg_ready | cfg_index, cfg_data
//
// Operations: set cell writes one occupancy cell, read path reads the path store,
// fill writes one cell per cycle through the occupancy memory write port. A search
// checks both endpoints, clears the node memory and seeds the start node, then per
// expansion scans all W*H cells for the open node of lowest f and updates each
// on-grid neighbour, then walks twice along the predecessors: once to count the
// path cells and once to write them into the path store.
// Synchronous active-high reset clears control state and restores a 32x32
// grid clipped to the maximum; the occupancy store is cleared by a sweep after
// reset, with busy high until the sweep ends. The receiver cannot stall: done pulses
// for one cycle and the block is ready again in that same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_astar_path_search_unit #(
  parameter int COST_WIDTH  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [4:0]  first_x,
  input  logic [4:0]  first_y,
  input  logic [4:0]  second_x,
  input  logic [4:0]  second_y,
  input  logic        blocked_value,
  input  logic        diagonal,
  input  logic [9:0]  path_index,
  output logic        done,
  output logic [1:0]  status,
  output logic [10:0] path_length,
  output logic [4:0]  path_x,
  output logic [4:0]  path_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import gaps_pkg::*;

  localparam int XW    = $clog2(MAX_COLUMNS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int LW    = $clog2(CELLS + 1);
  localparam int DW    = $clog2(MAX_COLUMNS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = COST_WIDTH;
  // node word: open, closed, pred valid, pred, g, f
  localparam int NW    = 3 + AW + 2 * CW;
  localparam int G_LO  = CW;
  localparam int P_LO  = 2 * CW;
  localparam int PV_B  = 2 * CW + AW;
  localparam int CL_B  = PV_B + 1;
  localparam int OP_B  = PV_B + 2;

  function automatic logic [DW-1:0] clamp_w(input logic [5:0] v);
    if (v == 6'd0) return DW'(1);
    if (32'(v) > MAX_COLUMNS) return DW'(MAX_COLUMNS);
    return DW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [5:0] v);
    if (v == 6'd0) return HW'(1);
    if (32'(v) > MAX_ROWS) return HW'(MAX_ROWS);
    return HW'(v);
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  // ---------------- state and registers ----------------
  state_t state, state_next;

  logic [DW-1:0] gw;
  logic [HW-1:0] gh;
  logic [LW-1:0] stored_length;
  logic          clr_done;            // occupancy cleared after reset
  logic [AW-1:0] sweep;
  logic          fill_v;
  logic [XW-1:0] sx_r, gx_r;
  logic [YW-1:0] sy_r, gy_r;
  logic          diag_r;
  logic          s_blk;
  logic [XW-1:0] scx;
  logic [YW-1:0] scy;
  logic          scan_v;
  logic [AW-1:0] scan_a;              // address whose data is on node_rd in the scan
  logic          have;
  logic [AW-1:0] best;
  logic [CW-1:0] best_f, best_g;
  logic          best_pv;
  logic [AW-1:0] best_pred;
  logic [3:0]    k;
  logic [AW-1:0] n_a;
  logic [CW-1:0] t_r;
  logic [AW-1:0] cur;
  logic [LW-1:0] len;
  logic [AW-1:0] pos;

  // ---------------- memories ----------------
  logic          occ_mem  [DEPTH];
  logic [NW-1:0] node_mem [DEPTH];
  logic [AW-1:0] path_mem [DEPTH];

  logic          occ_we, occ_wd, occ_rd;
  logic [AW-1:0] occ_wa, occ_ra;
  logic          node_we;
  logic [NW-1:0] node_wd, node_rd;
  logic [AW-1:0] node_wa, node_ra;
  logic          path_we;
  logic [AW-1:0] path_wa, path_wd, path_ra, path_rd;

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    occ_rd <= occ_mem[occ_ra];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_rd <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[path_wa] <= path_wd;
    end
    path_rd <= path_mem[path_ra];
  end

  // ---------------- decode ----------------
  logic          acc;
  logic [AW-1:0] port_a, start_a, goal_a;
  logic          inv_first, inv_second, rd_bad;
  logic          last_x, last_y, sweep_last;
  logic [3:0]    kmax;
  logic [XW+1:0] nx_u;
  logic [YW+1:0] ny_u;
  logic          inb;
  logic [AW-1:0] n_addr;
  logic [XW-1:0] bx, hx;
  logic [YW-1:0] by, hy;
  logic [CW-1:0] h_val;
  logic [8:0]    step;
  logic          relax;
  logic          len_more;

  assign busy      = (state != ST_IDLE) || !clr_done;
  assign acc       = start && !busy;
  assign cfg_ready = 1'b1;

  assign port_a  = {YW'(first_y), XW'(first_x)};
  assign start_a = {sy_r, sx_r};
  assign goal_a  = {gy_r, gx_r};

  assign inv_first  = (32'(first_x) >= 32'(gw)) || (32'(first_y) >= 32'(gh));
  assign inv_second = (32'(second_x) >= 32'(gw)) || (32'(second_y) >= 32'(gh));
  assign rd_bad     = (32'(path_index) >= 32'(stored_length)) ||
                      (32'(path_index) >= CELLS);

  assign last_x     = (32'(scx) + 32'd1 == 32'(gw));
  assign last_y     = (32'(scy) + 32'd1 == 32'(gh));
  assign sweep_last = (sweep == {AW{1'b1}});
  assign kmax       = diag_r ? 4'd8 : 4'd4;

  // neighbour of the expanded node; top bit set means it fell off the low edge
  assign bx     = best[XW-1:0];
  assign by     = best[AW-1:XW];
  assign nx_u   = {2'b00, bx} + {{XW{NB_DX[k[2:0]][1]}}, NB_DX[k[2:0]]};
  assign ny_u   = {2'b00, by} + {{YW{NB_DY[k[2:0]][1]}}, NB_DY[k[2:0]]};
  assign inb    = !nx_u[XW+1] && !ny_u[YW+1] &&
                  (32'(nx_u) < 32'(gw)) && (32'(ny_u) < 32'(gh));
  assign n_addr = {ny_u[YW-1:0], nx_u[XW-1:0]};
  assign step   = k[2] ? STEP_DIAG : STEP_STRAIGHT;

  // heuristic: neighbour while expanding, start cell otherwise
  assign hx = (state == ST_NB_ADDR) ? nx_u[XW-1:0] : sx_r;
  assign hy = (state == ST_NB_ADDR) ? ny_u[YW-1:0] : sy_r;

  gaps_heur #(.XW(XW), .YW(YW), .CW(CW)) u_heur (
    .clk  (clk),
    .x    (hx),
    .y    (hy),
    .gx   (gx_r),
    .gy   (gy_r),
    .diag (diag_r),
    .h    (h_val)
  );

  assign relax = !occ_rd && !node_rd[CL_B] &&
                 (!node_rd[OP_B] || (t_r < node_rd[G_LO +: CW]));
  assign len_more = node_rd[PV_B] && (32'(len) + 32'd1 < CELLS);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (kind)
            KIND_FILL: state_next = ST_FILL;
            KIND_FIND: if (!inv_first && !inv_second) state_next = ST_CHK_S;
            KIND_READ: if (!rd_bad) state_next = ST_PRD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL:      if (sweep_last) state_next = ST_IDLE;
      ST_PRD:       state_next = ST_IDLE;
      ST_CHK_S:     state_next = ST_CHK_G;
      ST_CHK_G:     state_next = ST_CHK_D;
      ST_CHK_D:     state_next = (s_blk || occ_rd) ? ST_IDLE : ST_CLR;
      ST_CLR:       if (sweep_last) state_next = ST_INIT;
      ST_INIT:      state_next = ST_SCAN;
      ST_SCAN:      if (last_x && last_y) state_next = ST_SCAN_WAIT;
      ST_SCAN_WAIT: state_next = ST_SCAN_DONE;
      ST_SCAN_DONE: begin
        if (!have)              state_next = ST_IDLE;
        else if (best == goal_a) state_next = ST_LEN_RD;
        else                    state_next = ST_NB_ADDR;
      end
      ST_NB_ADDR: begin
        if (k == kmax) state_next = ST_SCAN;
        else if (inb)  state_next = ST_NB_UPD;
      end
      ST_NB_UPD:  state_next = ST_NB_ADDR;
      ST_LEN_RD:  state_next = ST_LEN_DT;
      ST_LEN_DT:  state_next = len_more ? ST_LEN_RD : ST_WR_RD;
      ST_WR_RD:   state_next = ST_WR_DT;
      ST_WR_DT:   state_next = (pos == '0 || !node_rd[PV_B]) ? ST_IDLE : ST_WR_RD;
      default:    state_next = ST_IDLE;
    endcase
  end

  // ---------------- memory control and result ----------------
  logic          fire;
  logic [1:0]    fire_status;
  logic [XW-1:0] fire_px;
  logic [YW-1:0] fire_py;
  logic          sl_we;
  logic [LW-1:0] sl_wd;
  logic          scan_init;

  always_comb begin
    occ_we      = 1'b0;
    occ_wa      = sweep;
    occ_wd      = 1'b0;
    occ_ra      = start_a;
    node_we     = 1'b0;
    node_wa     = sweep;
    node_wd     = {3'b000, {AW{1'b0}}, {CW{1'b1}}, {CW{1'b1}}};
    node_ra     = cur;
    path_we     = 1'b0;
    path_wa     = pos;
    path_wd     = cur;
    path_ra     = AW'(path_index);
    fire        = 1'b0;
    fire_status = STATUS_OK;
    fire_px     = '0;
    fire_py     = '0;
    sl_we       = 1'b0;
    sl_wd       = '0;
    scan_init   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!clr_done) begin
          // post-reset clearing of the occupancy store
          occ_we = 1'b1;
        end else if (acc) begin
          case (kind)
            KIND_SET: begin
              fire = 1'b1;
              if (inv_first) begin
                fire_status = STATUS_INVALID;
              end else begin
                occ_we = 1'b1;
                occ_wa = port_a;
                occ_wd = blocked_value;
              end
            end
            KIND_FIND: begin
              if (inv_first || inv_second) begin
                fire        = 1'b1;
                fire_status = STATUS_INVALID;
              end
            end
            KIND_READ: begin
              if (rd_bad) begin
                fire        = 1'b1;
                fire_status = STATUS_INVALID;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        occ_we = 1'b1;
        occ_wd = fill_v;
        fire   = sweep_last;
      end
      ST_PRD: begin
        fire    = 1'b1;
        fire_px = path_rd[XW-1:0];
        fire_py = path_rd[AW-1:XW];
      end
      ST_CHK_S: occ_ra = start_a;
      ST_CHK_G: occ_ra = goal_a;
      ST_CHK_D: begin
        if (s_blk || occ_rd) begin
          fire        = 1'b1;
          fire_status = STATUS_NOTFOUND;
        end
      end
      ST_CLR: node_we = 1'b1;
      ST_INIT: begin
        node_we   = 1'b1;
        node_wa   = start_a;
        node_wd   = {3'b100, {AW{1'b0}}, {CW{1'b0}}, h_val};
        scan_init = 1'b1;
      end
      ST_SCAN: node_ra = {scy, scx};
      ST_SCAN_DONE: begin
        if (!have) begin
          fire        = 1'b1;
          fire_status = STATUS_NOTFOUND;
          sl_we       = 1'b1;
        end else if (best != goal_a) begin
          // move the chosen node to the closed set
          node_we = 1'b1;
          node_wa = best;
          node_wd = {2'b01, best_pv, best_pred, best_g, best_f};
        end
      end
      ST_NB_ADDR: begin
        if (k == kmax) begin
          scan_init = 1'b1;
        end else begin
          node_ra = n_addr;
          occ_ra  = n_addr;
        end
      end
      ST_NB_UPD: begin
        if (relax) begin
          node_we = 1'b1;
          node_wa = n_a;
          node_wd = {3'b101, best, t_r, sat_add(t_r, h_val)};
        end
      end
      ST_LEN_RD: node_ra = cur;
      ST_WR_RD: begin
        path_we = 1'b1;
        node_ra = cur;
      end
      ST_WR_DT: begin
        if (pos == '0 || !node_rd[PV_B]) begin
          fire  = 1'b1;
          sl_we = 1'b1;
          sl_wd = len;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      gw            <= clamp_w(6'd32);
      gh            <= clamp_h(6'd32);
      stored_length <= '0;
      clr_done      <= 1'b0;
      sweep         <= '0;
      scan_v        <= 1'b0;
      have          <= 1'b0;
      done          <= 1'b0;
    end else begin
      state  <= state_next;
      done   <= fire;
      scan_v <= (state == ST_SCAN);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH)  gw <= clamp_w(cfg_data);
        if (cfg_index == CFG_HEIGHT) gh <= clamp_h(cfg_data);
      end
      if (sl_we) stored_length <= sl_wd;
      // shared sweep counter: post-reset clear, fill and node clear
      if ((state == ST_IDLE && !clr_done) || state == ST_FILL || state == ST_CLR) begin
        sweep <= sweep + 1'b1;
        if (state == ST_IDLE && sweep_last) clr_done <= 1'b1;
      end
      if (scan_init) begin
        have <= 1'b0;
      end else if (scan_v && node_rd[OP_B] && (!have || node_rd[CW-1:0] < best_f)) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fill_v <= blocked_value;
      sx_r   <= XW'(first_x);
      sy_r   <= YW'(first_y);
      gx_r   <= XW'(second_x);
      gy_r   <= YW'(second_y);
      diag_r <= diagonal;
    end
    if (state == ST_CHK_G) s_blk <= occ_rd;

    // scan counters and running minimum
    if (scan_init) begin
      scx <= '0;
      scy <= '0;
    end else if (state == ST_SCAN) begin
      if (last_x) begin
        scx <= '0;
        scy <= scy + 1'b1;
      end else begin
        scx <= scx + 1'b1;
      end
    end
    scan_a <= {scy, scx};
    if (scan_v && node_rd[OP_B] && (!have || node_rd[CW-1:0] < best_f)) begin
      best      <= scan_a;
      best_f    <= node_rd[CW-1:0];
      best_g    <= node_rd[G_LO +: CW];
      best_pv   <= node_rd[PV_B];
      best_pred <= node_rd[P_LO +: AW];
    end

    case (state)
      ST_SCAN_DONE: begin
        k   <= '0;
        cur <= goal_a;
        len <= '0;
      end
      ST_NB_ADDR: begin
        if (k != kmax) begin
          if (inb) begin
            n_a <= n_addr;
            t_r <= sat_add(best_g, CW'(step));
          end else begin
            k <= k + 4'd1;
          end
        end
      end
      ST_NB_UPD: k <= k + 4'd1;
      ST_LEN_DT: begin
        len <= len + 1'b1;
        if (len_more) begin
          cur <= node_rd[P_LO +: AW];
        end else begin
          pos <= AW'(len);
          cur <= goal_a;
        end
      end
      ST_WR_DT: begin
        pos <= pos - 1'b1;
        cur <= node_rd[P_LO +: AW];
      end
      default: ;
    endcase

    status      <= fire_status;
    path_length <= 11'(sl_we ? sl_wd : stored_length);
    path_x      <= 5'(fire_px);
    path_y      <= 5'(fire_py);
  end

  // ---------------- assertions ----------------
  `ASSERT_ALWAYS(a_done_after_cmd, clk, rst,
    !done || $past(busy) || $past(start))
  `ASSERT_ALWAYS(a_status_code, clk, rst,
    !done || status == STATUS_OK || status == STATUS_INVALID || status == STATUS_NOTFOUND)
  `ASSERT_NEXT(a_upd_after_addr, clk, rst,
    state != ST_NB_ADDR, state != ST_NB_UPD)
  `ASSERT_ALWAYS(a_idle_not_busy, clk, rst,
    !(state == ST_IDLE && clr_done) || !busy)

endmodule
